>>> rtl/blb_pkg.sv
package blb_pkg;

  localparam int NumLists  = 8;
  localparam int ListDepth = 8;
  localparam int StoreSize = NumLists * ListDepth;
  localparam int LiW       = $clog2(NumLists);
  localparam int IdxW      = $clog2(ListDepth);
  localparam int AddrW     = $clog2(StoreSize);
  localparam int CntW      = $clog2(ListDepth + 1);
  localparam int NW        = $clog2(StoreSize + 1);

  typedef enum logic [3:0] {
    OP_CREATE    = 4'd0,
    OP_APPEND    = 4'd1,
    OP_DROP      = 4'd2,
    OP_DELETE    = 4'd3,
    OP_RESIZE    = 4'd4,
    OP_COUNT     = 4'd5,
    OP_READ      = 4'd6,
    OP_READ_SORT = 4'd7,
    OP_READ_ALL  = 4'd8,
    OP_ALL_SORT  = 4'd9
  } op_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_BAD_POS   = 4'd1,
    ST_EXISTS    = 4'd2,
    ST_BAD_SIZE  = 4'd3,
    ST_NO_MEM    = 4'd4,
    ST_FULL      = 4'd5,
    ST_NO_LIST   = 4'd6,
    ST_EMPTY     = 4'd7,
    ST_NOT_FOUND = 4'd8,
    ST_ALL_EMPTY = 4'd9
  } status_t;

  typedef struct packed {
    logic [3:0]        opcode;
    logic [3:0]        list_number;
    logic signed [31:0] item_value;
    logic signed [7:0]  amount;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         status;
    logic               data_valid;
    logic signed [31:0] data_out;
    logic [3:0]         count_out;
    logic               last;
  } rsp_t;

endpackage

>>> rtl/bounded_list_bank.sv
// bank of numbered bounded lists kept in one element memory with a registered
// read, plus a gather memory for read-outs. an item is taken at a clock edge
// where start is high and busy is low. each result sits on rsp for exactly
// one cycle with done high, because the receiver cannot stall. create,
// append, drop, resize, count and bad positions finish at the accepting edge.
// their single result follows in the next cycle and busy never rises, so the
// next item can follow right away. unused opcodes are taken and give no
// result. delete searches from the head and then shifts the later values down
// by one slot. read ops first gather the values, then stream the results out
// one by one while busy stays high. sorted reads run one selection pass per
// result instead. busy drops in the cycle that carries the final result.
module bounded_list_bank (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  blb_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output blb_pkg::rsp_t    rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEL_RD, S_DEL_CHK, S_SH_RD, S_SH_WR, S_G_RD, S_G_WR,
    S_SORT_RD, S_SORT_CMP, S_SORT_SWAP, S_OUT_RD, S_OUT
  } state_t;

  // element memory and gather memory
  logic signed [31:0] mem [blb_pkg::StoreSize];
  logic signed [31:0] gat [blb_pkg::StoreSize];
  logic [blb_pkg::AddrW-1:0] m_ra, g_ra;
  logic signed [31:0] m_rd, g_rd;
  logic m_we, g_we;
  logic [blb_pkg::AddrW-1:0] m_wa, g_wa;
  logic signed [31:0] m_wd, g_wd;

  always_ff @(posedge clk) begin
    if (m_we) mem[m_wa] <= m_wd;
    m_rd <= mem[m_ra];
  end
  always_ff @(posedge clk) begin
    if (g_we) gat[g_wa] <= g_wd;
    g_rd <= gat[g_ra];
  end

  logic [blb_pkg::CntW-1:0] cap [blb_pkg::NumLists];
  logic [blb_pkg::CntW-1:0] cnt [blb_pkg::NumLists];

  state_t state;
  blb_pkg::cmd_t c;
  logic [blb_pkg::LiW-1:0] li;
  logic [blb_pkg::CntW-1:0] i;       // index within a list
  logic [blb_pkg::NW-1:0]  n, k, j, mn_idx;
  logic signed [31:0]      mn_val, sv;
  logic                    sorted;
  logic                    walk_all; // gather every list, not just one

  // element address of slot x in list l
  function automatic logic [blb_pkg::AddrW-1:0] addr(
    input logic [blb_pkg::LiW-1:0] l, input logic [blb_pkg::CntW-1:0] x);
    return blb_pkg::AddrW'(l) * blb_pkg::AddrW'(blb_pkg::ListDepth)
           + blb_pkg::AddrW'(x);
  endfunction

  // combinational decode of a new command
  logic [3:0] pos;
  logic pos_ok;
  logic [blb_pkg::LiW-1:0] nli;
  logic signed [9:0] amt, nc;
  assign pos    = cmd.list_number;
  assign pos_ok = (pos >= 4'd1) && ({1'b0, pos} <= 5'(blb_pkg::NumLists));
  assign nli    = blb_pkg::LiW'(pos - 4'd1);
  assign amt    = 10'(cmd.amount);
  assign nc     = 10'(signed'({1'b0, cap[nli]})) + amt;

  assign busy = (state != S_IDLE);

  always_comb begin
    m_we = 1'b0; m_wa = addr(li, i); m_wd = c.item_value;
    m_ra = addr(li, i);
    g_we = 1'b0; g_wa = n[blb_pkg::AddrW-1:0]; g_wd = m_rd;
    g_ra = k[blb_pkg::AddrW-1:0];
    case (state)
      S_IDLE: begin
        m_wa = addr(nli, cnt[nli]);
        m_wd = cmd.item_value;
        m_we = start && pos_ok && cmd.opcode == blb_pkg::OP_APPEND
               && cap[nli] != '0 && cnt[nli] < cap[nli];
      end
      S_SH_RD:  m_ra = addr(li, i + 1'b1);
      S_SH_WR: begin
        m_we = 1'b1; m_wd = m_rd;
      end
      S_G_WR:   g_we = 1'b1;
      S_SORT_RD, S_SORT_CMP: g_ra = j[blb_pkg::AddrW-1:0];
      S_SORT_SWAP: begin
        // old value at position k moves into the slot the minimum came from
        g_we = 1'b1; g_wa = mn_idx[blb_pkg::AddrW-1:0]; g_wd = sv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    blb_pkg::rsp_t r;
    logic          d;
    r      = '0;
    r.last = 1'b1;
    d      = 1'b0;
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      for (int q = 0; q < blb_pkg::NumLists; q++) begin
        cap[q] <= '0; cnt[q] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: if (start && cmd.opcode <= blb_pkg::OP_ALL_SORT) begin
          c <= cmd; i <= '0; k <= '0; n <= '0;
          sorted <= (cmd.opcode == blb_pkg::OP_READ_SORT)
                    || (cmd.opcode == blb_pkg::OP_ALL_SORT);
          walk_all <= (cmd.opcode == blb_pkg::OP_READ_ALL)
                      || (cmd.opcode == blb_pkg::OP_ALL_SORT);
          if (cmd.opcode == blb_pkg::OP_READ_ALL || cmd.opcode == blb_pkg::OP_ALL_SORT) begin
            li <= '0; state <= S_G_RD;
          end else begin
            li <= nli;
            d = 1'b1;
            if (!pos_ok) r.status = blb_pkg::ST_BAD_POS;
            else if (cmd.opcode == blb_pkg::OP_CREATE) begin
              if (cap[nli] != '0) r.status = blb_pkg::ST_EXISTS;
              else if (amt < 10'sd1) r.status = blb_pkg::ST_BAD_SIZE;
              else if (amt > 10'(blb_pkg::ListDepth)) r.status = blb_pkg::ST_NO_MEM;
              else begin
                cap[nli] <= blb_pkg::CntW'(amt); cnt[nli] <= '0;
              end
            end else if (cap[nli] == '0) r.status = blb_pkg::ST_NO_LIST;
            else case (cmd.opcode)
              blb_pkg::OP_APPEND:
                if (cnt[nli] >= cap[nli]) r.status = blb_pkg::ST_FULL;
                else cnt[nli] <= cnt[nli] + 1'b1;
              blb_pkg::OP_DROP:
                if (cnt[nli] == '0) r.status = blb_pkg::ST_EMPTY;
                else cnt[nli] <= cnt[nli] - 1'b1;
              blb_pkg::OP_DELETE:
                if (cnt[nli] == '0) r.status = blb_pkg::ST_EMPTY;
                else begin d = 1'b0; state <= S_DEL_RD; end
              blb_pkg::OP_RESIZE:
                if (nc < 10'sd1) r.status = blb_pkg::ST_BAD_SIZE;
                else if (nc > 10'(blb_pkg::ListDepth)) r.status = blb_pkg::ST_NO_MEM;
                else begin
                  cap[nli] <= blb_pkg::CntW'(nc);
                  if (10'(cnt[nli]) > nc) cnt[nli] <= blb_pkg::CntW'(nc);
                end
              blb_pkg::OP_COUNT:
                if (cnt[nli] == '0) r.status = blb_pkg::ST_EMPTY;
                else r.count_out = 4'(cnt[nli]);
              default: begin
                d = 1'b0; state <= S_G_RD;
              end
            endcase
          end
        end
        // delete: search
        S_DEL_RD: state <= S_DEL_CHK;
        S_DEL_CHK:
          if (m_rd == c.item_value) begin
            if (i + 1'b1 < cnt[li]) state <= S_SH_RD;
            else begin
              cnt[li] <= cnt[li] - 1'b1; d = 1'b1; state <= S_IDLE;
            end
          end else if (i + 1'b1 >= cnt[li]) begin
            r.status = blb_pkg::ST_NOT_FOUND; d = 1'b1; state <= S_IDLE;
          end else begin
            i <= i + 1'b1; state <= S_DEL_RD;
          end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR:
          if (i + 2'd2 < cnt[li]) begin
            i <= i + 1'b1; state <= S_SH_RD;
          end else begin
            cnt[li] <= cnt[li] - 1'b1; d = 1'b1; state <= S_IDLE;
          end
        // gather one list, or every list in order
        S_G_RD:
          if (i < cnt[li]) state <= S_G_WR;
          else if (!walk_all || li == blb_pkg::LiW'(blb_pkg::NumLists - 1)) begin
            if (n == '0) begin
              d = 1'b1; state <= S_IDLE;
              if (walk_all) r.status = blb_pkg::ST_ALL_EMPTY;
            end else begin
              k <= '0; j <= '0; state <= sorted ? S_SORT_RD : S_OUT_RD;
            end
          end else begin
            li <= li + 1'b1; i <= '0;
          end
        S_G_WR: begin
          n <= n + 1'b1; i <= i + 1'b1; state <= S_G_RD;
        end
        // selection sort: position k, scan j from k
        S_SORT_RD: state <= S_SORT_CMP;
        S_SORT_CMP: begin
          if (j == k) begin
            mn_idx <= k; mn_val <= g_rd; sv <= g_rd;
          end else if (g_rd < mn_val) begin
            mn_idx <= j; mn_val <= g_rd;
          end
          if (j + 1'b1 < n) begin j <= j + 1'b1; state <= S_SORT_RD; end
          else state <= S_SORT_SWAP;
        end
        S_SORT_SWAP: begin
          // minimum of the remaining values goes out at position k
          d = 1'b1;
          r.data_valid = 1'b1;
          r.data_out = mn_val;
          r.last = (k + 1'b1 == n);
          if (k + 1'b1 == n) state <= S_IDLE;
          else begin
            k <= k + 1'b1; j <= k + 1'b1; state <= S_SORT_RD;
          end
        end
        S_OUT_RD: state <= S_OUT;
        S_OUT: begin
          d = 1'b1;
          r.data_valid = 1'b1;
          r.data_out = g_rd;
          r.last = (k + 1'b1 == n);
          if (k + 1'b1 == n) state <= S_IDLE;
          else begin
            k <= k + 1'b1; state <= S_OUT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
      done <= d;
      rsp  <= r;
    end
  end

`ifndef SYNTH
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.last |-> busy) else $error("stream ended early");
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    done && rsp.data_valid |-> rsp.status == blb_pkg::ST_OK) else $error("bad data status");
`endif

endmodule
